FILE: design/ecpc_pkg.sv
// Shared types and constants for the coin passage capture block.
package ecpc_pkg;

   // Sample buffer depth and counter widths
   localparam int unsigned BUF_DEPTH  = 1024;
   localparam int unsigned CNT_W      = 11;
   localparam int unsigned SUM_W      = 18;
   localparam int unsigned TIMEOUT_W  = 16;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W     = 2;
   localparam int unsigned QCNT_W     = 3;

   localparam logic [CNT_W-1:0] BUF_DEPTH_C = CNT_W'(BUF_DEPTH);

   // History patterns that qualify and release a sensor
   localparam logic [3:0] HIST_ALL = 4'hf;
   localparam logic [3:0] HIST_NONE = 4'h0;

   // Register indexes on the csr port (byte address / 4)
   localparam logic [2:0] REG_ENTRY_BASE   = 3'd0;
   localparam logic [2:0] REG_EXIT_BASE    = 3'd1;
   localparam logic [2:0] REG_ENTRY_OFFSET = 3'd2;
   localparam logic [2:0] REG_EXIT_OFFSET  = 3'd3;
   localparam logic [2:0] REG_PASS_TIMEOUT = 3'd4;

   // Item kinds carried on req_tuser
   localparam logic CMD_SAMPLE   = 1'b0;
   localparam logic CMD_BASELINE = 1'b1;

   typedef struct packed {
      logic [7:0]           entry_base;
      logic [7:0]           exit_base;
      logic [7:0]           entry_offset;
      logic [7:0]           exit_offset;
      logic [TIMEOUT_W-1:0] pass_timeout;
   } cfg_type;

   // Classified item handed from front to back
   typedef struct packed {
      logic             cmd;
      logic [CNT_W-1:0] idle_count;
      logic             accumulate_base;
      logic [7:0]       entry_sample;
      logic [7:0]       middle_sample;
      logic [7:0]       exit_sample;
      logic             entry_hit;
      logic             exit_hit;
   } item_type;

endpackage

FILE: design/ecpc_csr.sv
// Configuration registers with an APB-style access port.
module ecpc_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [4:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output ecpc_pkg::cfg_type    cfg
);

   ecpc_pkg::cfg_type cfg_ff;
   logic              wr_en;
   logic [2:0]        reg_idx;

   assign wr_en   = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx = csr_paddr[4:2];
   assign cfg     = cfg_ff;

   // Write registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.entry_base   <= 8'd0;
         cfg_ff.exit_base    <= 8'd0;
         cfg_ff.entry_offset <= 8'd16;
         cfg_ff.exit_offset  <= 8'd16;
         cfg_ff.pass_timeout <= 16'd200;
      end else if (wr_en) begin
         unique case (reg_idx)
            ecpc_pkg::REG_ENTRY_BASE:   cfg_ff.entry_base   <= csr_pwdata[7:0];
            ecpc_pkg::REG_EXIT_BASE:    cfg_ff.exit_base    <= csr_pwdata[7:0];
            ecpc_pkg::REG_ENTRY_OFFSET: cfg_ff.entry_offset <= csr_pwdata[7:0];
            ecpc_pkg::REG_EXIT_OFFSET:  cfg_ff.exit_offset  <= csr_pwdata[7:0];
            ecpc_pkg::REG_PASS_TIMEOUT: cfg_ff.pass_timeout <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         ecpc_pkg::REG_ENTRY_BASE:   csr_prdata = {24'd0, cfg_ff.entry_base};
         ecpc_pkg::REG_EXIT_BASE:    csr_prdata = {24'd0, cfg_ff.exit_base};
         ecpc_pkg::REG_ENTRY_OFFSET: csr_prdata = {24'd0, cfg_ff.entry_offset};
         ecpc_pkg::REG_EXIT_OFFSET:  csr_prdata = {24'd0, cfg_ff.exit_offset};
         ecpc_pkg::REG_PASS_TIMEOUT: csr_prdata = {16'd0, cfg_ff.pass_timeout};
         default:                    csr_prdata = 32'd0;
      endcase
   end

endmodule

FILE: design/ecpc_front.sv
// Front end: unpack an input item, clamp the count and qualify the sensor samples.
module ecpc_front (
   input  logic                 req_tuser,   // [0] cmd
   input  logic [39:0]          req_tdata,   // idle_count, accumulate_base, entry, middle, exit
   input  ecpc_pkg::cfg_type    cfg,
   output ecpc_pkg::item_type   item
);

   logic [10:0] idle_raw;
   logic [8:0]  entry_thr;
   logic [8:0]  exit_sum;

   assign idle_raw = req_tdata[10:0];

   // Entry threshold without wrap; a threshold above 255 never matches
   assign entry_thr = {1'b0, cfg.entry_base} + {1'b0, cfg.entry_offset};
   // Exit: sample < base - offset, rewritten as sample + offset < base
   assign exit_sum  = {1'b0, req_tdata[35:28]} + {1'b0, cfg.exit_offset};

   always_comb begin
      item.cmd             = req_tuser;
      item.idle_count      = (idle_raw > ecpc_pkg::BUF_DEPTH_C) ? ecpc_pkg::BUF_DEPTH_C
                                                                : idle_raw;
      item.accumulate_base = req_tdata[11];
      item.entry_sample    = req_tdata[19:12];
      item.middle_sample   = req_tdata[27:20];
      item.exit_sample     = req_tdata[35:28];
      item.entry_hit       = {1'b0, req_tdata[19:12]} > entry_thr;
      item.exit_hit        = exit_sum < {1'b0, cfg.exit_base};
   end

endmodule

FILE: design/ecpc_queue.sv
// Short item queue between the front end and the back end.
module ecpc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ecpc_pkg::item_type   push_item,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output ecpc_pkg::item_type   head_item
);

   ecpc_pkg::item_type                   slot_ff [ecpc_pkg::QUEUE_DEPTH];
   logic [ecpc_pkg::QPTR_W-1:0]          wr_ptr_ff;
   logic [ecpc_pkg::QPTR_W-1:0]          rd_ptr_ff;
   logic [ecpc_pkg::QCNT_W-1:0]          count_ff;
   logic                                 do_push;
   logic                                 do_pop;

   assign full       = count_ff == ecpc_pkg::QCNT_W'(ecpc_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_item  = slot_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   // Store payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: design/ecpc_back.sv
// Back end: baseline capture, passage tracking and the result register.
module ecpc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  ecpc_pkg::cfg_type    cfg,
   input  logic                 head_valid,
   input  ecpc_pkg::item_type   head_item,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [103:0]         rsp_tdata,
   output logic                 rsp_tuser
);

   localparam int unsigned CW = ecpc_pkg::CNT_W;
   localparam int unsigned SW = ecpc_pkg::SUM_W;
   localparam int unsigned TW = ecpc_pkg::TIMEOUT_W;

   // Detection and capture state
   logic [3:0]    entry_hist_ff, entry_hist_in;
   logic [3:0]    exit_hist_ff, exit_hist_in;
   logic          entry_seen_ff, entry_seen_in;
   logic          exit_seen_ff, exit_seen_in;
   logic          open_ff, open_in;
   logic [TW-1:0] timeout_ff, timeout_in;
   logic [CW-1:0] index_ff, index_in;
   logic [CW-1:0] base_left_ff, base_left_in;
   logic          base_acc_ff, base_acc_in;
   logic [SW-1:0] sum_e_ff, sum_e_in;
   logic [SW-1:0] sum_m_ff, sum_m_in;
   logic [SW-1:0] sum_x_ff, sum_x_in;

   // Result register
   logic          rsp_valid_ff;
   logic [103:0]  rsp_data_ff, rsp_data_in;
   logic          rsp_user_ff, rsp_user_in;

   logic          store;
   logic          passed;
   logic          done;
   logic [CW-1:0] idx;
   logic [CW-1:0] len;

   assign pop        = head_valid & (~rsp_valid_ff | rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Step the state for the item at the queue head
   always_comb begin
      entry_hist_in = entry_hist_ff;
      exit_hist_in  = exit_hist_ff;
      entry_seen_in = entry_seen_ff;
      exit_seen_in  = exit_seen_ff;
      open_in       = open_ff;
      timeout_in    = timeout_ff;
      index_in      = index_ff;
      base_left_in  = base_left_ff;
      base_acc_in   = base_acc_ff;
      sum_e_in      = sum_e_ff;
      sum_m_in      = sum_m_ff;
      sum_x_in      = sum_x_ff;
      store         = 1'b0;
      passed        = 1'b0;
      done          = 1'b0;
      idx           = '0;
      len           = '0;

      if (head_item.cmd == ecpc_pkg::CMD_BASELINE) begin
         // Start a baseline run: reload count, clear index and sums
         base_left_in = head_item.idle_count;
         base_acc_in  = head_item.accumulate_base;
         index_in     = '0;
         sum_e_in     = '0;
         sum_m_in     = '0;
         sum_x_in     = '0;
      end else if (base_left_ff != '0) begin
         // Baseline sample: store it, detection frozen
         base_left_in = base_left_ff - 1'b1;
         store        = 1'b1;
         idx          = index_ff;
         index_in     = index_ff + 1'b1;
         if (base_acc_ff) begin
            sum_e_in = sum_e_ff + SW'(head_item.entry_sample);
            sum_m_in = sum_m_ff + SW'(head_item.middle_sample);
            sum_x_in = sum_x_ff + SW'(head_item.exit_sample);
         end
         if (base_left_in == '0) begin
            done = 1'b1;
            len  = index_in;
         end
      end else begin
         entry_hist_in = {entry_hist_ff[2:0], head_item.entry_hit};
         exit_hist_in  = {exit_hist_ff[2:0], head_item.exit_hit};

         // Entry sensor opens the passage and arms the timeout on release
         if (!entry_seen_ff) begin
            if (entry_hist_in == ecpc_pkg::HIST_ALL) begin
               entry_seen_in = 1'b1;
               if (!open_ff) begin
                  open_in    = 1'b1;
                  index_in   = '0;
                  timeout_in = '0;
               end
            end
         end else if (entry_hist_in == ecpc_pkg::HIST_NONE) begin
            entry_seen_in = 1'b0;
            if (open_ff) begin
               timeout_in = cfg.pass_timeout;
            end
         end

         // Exit release or timeout closes the passage
         if (open_in) begin
            if (!exit_seen_ff) begin
               if (exit_hist_in == ecpc_pkg::HIST_ALL) begin
                  exit_seen_in = 1'b1;
               end
            end else if (exit_hist_in == ecpc_pkg::HIST_NONE) begin
               exit_seen_in = 1'b0;
               open_in      = 1'b0;
               passed       = 1'b1;
               len          = index_in;
            end
            if (timeout_in != '0) begin
               timeout_in = timeout_in - 1'b1;
               if (timeout_in == '0) begin
                  exit_seen_in = 1'b0;
                  open_in      = 1'b0;
                  passed       = 1'b1;
                  len          = index_in;
               end
            end
         end

         // Store while the passage is open and the buffer has room
         if (open_in && (index_in < ecpc_pkg::BUF_DEPTH_C)) begin
            store    = 1'b1;
            idx      = index_in;
            index_in = index_in + 1'b1;
         end
      end

      // Pack the result: tuser = store_valid
      rsp_user_in = store;
      rsp_data_in = {2'b00, sum_x_in, sum_m_in, sum_e_in,
                     len, done, passed, open_in,
                     store ? head_item.exit_sample   : 8'd0,
                     store ? head_item.middle_sample : 8'd0,
                     store ? head_item.entry_sample  : 8'd0,
                     idx[9:0]};
   end

   // Hold state and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_hist_ff <= '0;
         exit_hist_ff  <= '0;
         entry_seen_ff <= 1'b0;
         exit_seen_ff  <= 1'b0;
         open_ff       <= 1'b0;
         timeout_ff    <= '0;
         index_ff      <= '0;
         base_left_ff  <= '0;
         base_acc_ff   <= 1'b0;
         sum_e_ff      <= '0;
         sum_m_ff      <= '0;
         sum_x_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (pop) begin
            entry_hist_ff <= entry_hist_in;
            exit_hist_ff  <= exit_hist_in;
            entry_seen_ff <= entry_seen_in;
            exit_seen_ff  <= exit_seen_in;
            open_ff       <= open_in;
            timeout_ff    <= timeout_in;
            index_ff      <= index_in;
            base_left_ff  <= base_left_in;
            base_acc_ff   <= base_acc_in;
            sum_e_ff      <= sum_e_in;
            sum_m_ff      <= sum_m_in;
            sum_x_ff      <= sum_x_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   // Result payload needs no reset
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

endmodule

FILE: design/eddy_coin_passage_capture_core.sv
// Top level of the eddy-sensor coin passage capture block.
// An accepted item passes through a queue slot and then the result register before
// its result can be taken.
// Throughput: one item per cycle while the queue has room; the back end retires one queued item per cycle
// whenever its result register is empty or being taken.
// Reset (synchronous, active high) clears queue, detection state, sums and
// result valid, and loads the configuration registers with their defaults.
module eddy_coin_passage_capture_core (
   input  logic         clock,
   input  logic         reset,
   // input items
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,   // idle_count[10:0], accumulate_base[11], entry_sample[19:12],
                                     // middle_sample[27:20], exit_sample[35:28], zero fill
   input  logic         req_tuser,   // cmd[0]
   // results
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // store_index[9:0], store_entry[17:10], store_middle[25:18],
                                     // store_exit[33:26], coin_present[34], coin_passed[35],
                                     // baseline_done[36], capture_length[47:37],
                                     // sum_entry[65:48], sum_middle[83:66], sum_exit[101:84]
   output logic         rsp_tuser,   // store_valid[0]
   // configuration
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   ecpc_pkg::cfg_type  cfg;
   ecpc_pkg::item_type front_item;
   ecpc_pkg::item_type head_item;
   logic               q_full;
   logic               head_valid;
   logic               pop;

   assign csr_pready = 1'b1;
   assign req_tready = ~q_full;

   ecpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   ecpc_front u_front (
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .cfg       (cfg),
      .item      (front_item)
   );

   ecpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_tvalid),
      .push_item  (front_item),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   ecpc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
